// ----- design/rtml_pkg.sv -----
`default_nettype none

package rtml_pkg;

   // Table geometry and fixed protocol values
   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;
   localparam logic [7:0]  PROTO_UDP           = 8'd17;
   localparam logic [15:0] METRIC_LIMIT_RESET  = 16'd10000;

   // Request commands
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   // Response status codes
   localparam logic [2:0] STAT_FORWARDED   = 3'd0;
   localparam logic [2:0] STAT_TTL_EXPIRED = 3'd1;
   localparam logic [2:0] STAT_NO_ROUTE    = 3'd2;
   localparam logic [2:0] STAT_NOT_UDP     = 3'd3;
   localparam logic [2:0] STAT_UPDATED     = 3'd4;
   localparam logic [2:0] STAT_INSERTED    = 3'd5;
   localparam logic [2:0] STAT_TABLE_FULL  = 3'd6;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  protocol;
      logic [31:0] dest_addr;
      logic [7:0]  ttl_in;
      logic [1:0]  in_port;
      logic [31:0] route_net;
      logic [31:0] route_mask;
      logic [15:0] route_metric;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  egress_port;
      logic [7:0]  ttl_out;
      logic [15:0] best_metric;
   } rsp_type;

   // One route as stored in the table memory
   typedef struct packed {
      logic [31:0] network;
      logic [31:0] mask;
      logic [1:0]  port;
      logic [15:0] metric;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_LAST,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- design/route_table_metric_lookup.sv -----
// The table is walked through S_WALK, one read per route held (up to TABLE_DEPTH),
// then S_LAST and S_FINISH; non-UDP requests, expired lookup TTLs and an empty table
// go straight to S_FINISH, which waits while the response register stays full, then registers it.
// One request is in flight at a time: the next is accepted once the block is idle
// again; the single read port, one entry per cycle, sets the walk rate.
// Reset (sync, active high) empties the table, sets metric_limit to 10000; memory not cleared.
`default_nettype none

module route_table_metric_lookup
   import rtml_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

   // Route memory, one entry per route
   entry_type entry_mem [TABLE_DEPTH];

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       limit_ff, limit_in;
   logic [15:0]       best_ff, best_in;
   logic [1:0]        port_ff, port_in;
   logic              found_ff, found_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type         hit_entry_ff, hit_entry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff;
   entry_type         rd_data_ff;

   logic              rd_issue;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;
   logic              out_free;
   logic              table_full;
   logic              idx_last;
   logic              needs_walk;
   entry_type         new_entry;
   rsp_type           result;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign idx_last   = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
   assign needs_walk = (req_data.protocol == PROTO_UDP)
                       && !(req_data.cmd == CMD_LOOKUP && req_data.ttl_in <= 8'd1)
                       && (count_ff != '0);

   assign new_entry.network = req_ff.route_net;
   assign new_entry.mask    = req_ff.route_mask;
   assign new_entry.port    = req_ff.in_port;
   assign new_entry.metric  = req_ff.route_metric;

   // Build the response from the request and the walk results
   always_comb begin
      result = '0;
      if (req_ff.protocol != PROTO_UDP) begin
         result.status = STAT_NOT_UDP;
      end else if (req_ff.cmd == CMD_LOOKUP) begin
         if (req_ff.ttl_in <= 8'd1) begin
            result.status = STAT_TTL_EXPIRED;
         end else if (found_ff) begin
            result.status      = STAT_FORWARDED;
            result.egress_port = port_ff;
            result.ttl_out     = req_ff.ttl_in - 8'd1;
            result.best_metric = best_ff;
         end else begin
            result.status = STAT_NO_ROUTE;
         end
      end else if (hit_ff) begin
         result.status = STAT_UPDATED;
      end else if (table_full) begin
         result.status = STAT_TABLE_FULL;
      end else begin
         result.status = STAT_INSERTED;
      end
   end

   // Compare stage, next state and control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      best_in      = best_ff;
      port_in      = port_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_valid_in  = 1'b0;
      rd_issue     = 1'b0;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = hit_ff ? hit_idx_ff : count_ff[IDX_W-1:0];
      mem_wdata    = hit_ff ? hit_entry_ff : new_entry;

      // Evaluate the entry read in the previous cycle
      if (rd_valid_ff) begin
         if (req_ff.cmd == CMD_LOOKUP) begin
            if ((req_ff.dest_addr & rd_data_ff.mask) == (rd_data_ff.network & rd_data_ff.mask)
                && rd_data_ff.metric < best_ff) begin
               best_in  = rd_data_ff.metric;
               port_in  = rd_data_ff.port;
               found_in = 1'b1;
            end
         end else if (rd_data_ff.network == req_ff.route_net
                      && rd_data_ff.mask == req_ff.route_mask) begin
            hit_in       = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_entry_in = rd_data_ff;
            if (rd_data_ff.port == req_ff.in_port) begin
               hit_entry_in.metric = req_ff.route_metric;
            end else if (rd_data_ff.metric > req_ff.route_metric) begin
               hit_entry_in.metric = req_ff.route_metric;
               hit_entry_in.port   = req_ff.in_port;
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               best_in  = limit_ff;
               port_in  = '0;
               found_in = 1'b0;
               hit_in   = 1'b0;
               state_in = needs_walk ? S_WALK : S_FINISH;
            end
         end
         S_WALK: begin
            // Read one entry per cycle up to the last valid route
            rd_issue    = 1'b1;
            rd_valid_in = 1'b1;
            if (idx_last) begin
               state_in = S_LAST;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_LAST: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // Commit table changes and the response together
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               state_in     = S_IDLE;
               if (req_ff.protocol == PROTO_UDP && req_ff.cmd == CMD_UPDATE) begin
                  if (hit_ff) begin
                     mem_we = 1'b1;
                  end else if (!table_full) begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         limit_ff     <= METRIC_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      port_ff      <= port_in;
      found_ff     <= found_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      rsp_data_ff  <= rsp_data_in;
      rd_idx_ff    <= idx_ff;
   end

   // Route memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_issue) begin
         rd_data_ff <= entry_mem[idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Route count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("route count exceeds table depth");

   // Table writes happen only while committing a request
   a_write_finish: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_FINISH && out_free))
      else $error("table write outside commit");

   // Count changes only together with a table write
   a_count_write: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> $past(mem_we))
      else $error("route count changed without a table write");

   // Read data is only evaluated during the walk
   a_read_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_WALK || state_ff == S_LAST))
      else $error("read data valid outside the walk");

   // An accepted request always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != S_IDLE)
      else $error("request accepted but block stayed idle");

endmodule

`default_nettype wire
